/* rtl/pza_pkg.sv */
`default_nettype none
package pza_pkg;

  // widths of the fixed payload fields
  localparam int KEY_W  = 32;
  localparam int TICK_W = 48;
  localparam int CNT_W  = 32;
  localparam int LVL_W  = 8;

  // request codes
  typedef enum logic [2:0] {
    REQ_FRESET   = 3'd0,
    REQ_START    = 3'd1,
    REQ_END      = 3'd2,
    REQ_FINISH   = 3'd3,
    REQ_RD_ENTRY = 3'd4,
    REQ_RD_HIST  = 3'd5
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_INSERT = 2'd1,
    ST_MISS   = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic rd;
    logic calc;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_req;
    logic found;
    logic exhausted;
    logic need_read;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/pza_ram.sv */
`default_nettype none
module pza_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/pza_ctrl.sv */
`default_nettype none
module pza_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire pza_pkg::stat_t st_i,
  output pza_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_READ,
    S_CALC,
    S_COMMIT
  } state_e;

  state_e state_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (st_i.scan_req) state_q <= S_SCAN;
          else if (st_i.need_read) state_q <= S_READ;
          else state_q <= S_CALC;
        end
        S_SCAN: begin
          if (st_i.found || st_i.exhausted) begin
            state_q <= st_i.need_read ? S_READ : S_CALC;
          end
        end
        S_READ:   state_q <= S_CALC;
        S_CALC:   state_q <= S_COMMIT;
        S_COMMIT: begin
          if (st_i.out_free) state_q <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.rd     = (state_q == S_READ);
    cmd_o.calc   = (state_q == S_CALC);
    cmd_o.commit = (state_q == S_COMMIT) && st_i.out_free;
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* rtl/pza_dpath.sv */
`default_nettype none
module pza_dpath #(
  parameter int ENTRIES       = 256,
  parameter int HISTORY_DEPTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pza_pkg::cmd_t               cmd_i,
  output pza_pkg::stat_t                   st_o,
  input  wire logic [2:0]                  req_type_i,
  input  wire logic [pza_pkg::KEY_W-1:0]   zone_key_i,
  input  wire logic [pza_pkg::TICK_W-1:0]  timestamp_i,
  input  wire logic [7:0]                  read_index_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic [1:0]                       status_o,
  output logic [7:0]                       entry_index_o,
  output logic [pza_pkg::CNT_W-1:0]        invoke_count_o,
  output logic [pza_pkg::TICK_W-1:0]       total_ticks_o,
  output logic [7:0]                       nesting_level_o,
  output logic [7:0]                       parent_index_o,
  output logic [8:0]                       entry_count_o,
  output logic [pza_pkg::TICK_W-1:0]       frame_ticks_o,
  output logic [pza_pkg::TICK_W-1:0]       history_ticks_o,
  output logic [5:0]                       history_count_o
);

  localparam int EIW = $clog2(ENTRIES);
  localparam int HIW = $clog2(HISTORY_DEPTH);
  localparam int TW  = pza_pkg::TICK_W;

  typedef struct packed {
    logic [pza_pkg::KEY_W-1:0] key;
    logic [TW-1:0]             stamp;
    logic [TW-1:0]             total;
    logic [pza_pkg::CNT_W-1:0] count;
    logic [pza_pkg::LVL_W-1:0] level;
    logic [EIW-1:0]            parent;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  // latched request
  logic [2:0]                req_q;
  logic [pza_pkg::KEY_W-1:0] key_q;
  logic [TW-1:0]             ts_q;
  logic [7:0]                ridx_q;

  // table and frame state
  logic [EIW:0]              used_q, used_d;
  logic [EIW-1:0]            cur_q, cur_d;
  logic [TW-1:0]             frame_q, frame_d;
  logic [TW-1:0]             rstamp_q, rstamp_d;
  logic [TW-1:0]             rtot_q, rtot_d;
  logic [HIW-1:0]            hptr_q, hptr_d;
  logic [HIW:0]              hfill_q, hfill_d;
  logic [HISTORY_DEPTH-1:0]  hval_q;

  // scan pipeline
  logic [EIW:0]              scan_idx_q;
  logic                      pend_q;
  logic [EIW-1:0]            pend_idx_q;
  logic                      found_q;
  logic [EIW-1:0]            hit_idx_q;

  // operands captured before commit
  entry_t                    ent_q;
  logic [TW-1:0]             el_q;
  logic [TW-1:0]             hist_q;

  // memories
  logic                      ent_we, ent_re, hist_we, hist_re;
  logic [EIW-1:0]            ent_waddr, ent_raddr;
  entry_t                    ent_wdata, ent_rdata;
  logic [TW-1:0]             hist_rdata;

  pza_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  pza_ram #(.WIDTH(TW), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hptr_q),
    .wdata_i (el_q),
    .re_i    (hist_re),
    .raddr_i (ridx_q[HIW-1:0]),
    .rdata_o (hist_rdata)
  );

  // request decode
  logic is_start, is_end, is_finish, is_rdent, is_rdhist;
  logic room, ridx_ok_e, ridx_ok_h, more, hit_now, issue;

  assign is_start  = (req_q == pza_pkg::REQ_START);
  assign is_end    = (req_q == pza_pkg::REQ_END);
  assign is_finish = (req_q == pza_pkg::REQ_FINISH);
  assign is_rdent  = (req_q == pza_pkg::REQ_RD_ENTRY);
  assign is_rdhist = (req_q == pza_pkg::REQ_RD_HIST);

  assign room      = (used_q != (EIW+1)'(ENTRIES));
  assign ridx_ok_e = (32'(ridx_q) < 32'(used_q));
  assign ridx_ok_h = (32'(ridx_q) < 32'(HISTORY_DEPTH));
  assign more      = (scan_idx_q < used_q);
  assign hit_now   = pend_q && (ent_rdata.key == key_q);
  assign issue     = cmd_i.scan && !found_q && !hit_now && more;

  // read port steering
  assign ent_re    = issue || (cmd_i.rd && (is_start || is_rdent));
  assign ent_raddr = cmd_i.scan ? scan_idx_q[EIW-1:0] : (is_start ? cur_q : EIW'(ridx_q));
  assign hist_re   = cmd_i.rd && is_rdhist;

  // status to controller
  always_comb begin
    st_o.scan_req  = is_start || is_end;
    st_o.found     = found_q;
    st_o.exhausted = !pend_q && !found_q && !more;
    st_o.need_read = (is_start && !found_q && room) || (is_rdent && ridx_ok_e) ||
                     (is_rdhist && ridx_ok_h);
    st_o.out_free  = !out_valid_o || !out_stall_i;
  end

  // request capture and operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      key_q  <= zone_key_i;
      ts_q   <= timestamp_i;
      ridx_q <= read_index_i;
    end
    if (cmd_i.scan) begin
      pend_idx_q <= scan_idx_q[EIW-1:0];
      if (hit_now) hit_idx_q <= pend_idx_q;
    end
    if (cmd_i.calc) begin
      ent_q  <= ent_rdata;
      el_q   <= ts_q - (is_finish ? rstamp_q : ent_rdata.stamp);
      hist_q <= hist_rdata;
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
    end else if (cmd_i.load) begin
      scan_idx_q <= (EIW+1)'(1);
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
    end else if (cmd_i.scan) begin
      pend_q <= issue;
      if (issue) scan_idx_q <= scan_idx_q + (EIW+1)'(1);
      if (hit_now) found_q <= 1'b1;
    end
  end

  // commit: next state and result
  logic [1:0]                r_status;
  logic [7:0]                r_idx, r_lvl, r_par;
  logic [pza_pkg::CNT_W-1:0] r_cnt;
  logic [TW-1:0]             r_tot, r_hist;
  logic [7:0]                new_lvl;
  entry_t                    upd;

  assign new_lvl = (cur_q == '0) ? 8'd1 :
                   ((ent_q.level == 8'hFF) ? 8'hFF : ent_q.level + 8'd1);

  always_comb begin
    r_status  = pza_pkg::ST_MISS;
    r_idx     = '0;
    r_cnt     = '0;
    r_tot     = '0;
    r_lvl     = '0;
    r_par     = '0;
    r_hist    = '0;
    used_d    = used_q;
    cur_d     = cur_q;
    frame_d   = frame_q;
    rstamp_d  = rstamp_q;
    rtot_d    = rtot_q;
    hptr_d    = hptr_q;
    hfill_d   = hfill_q;
    ent_we    = 1'b0;
    hist_we   = 1'b0;
    ent_waddr = hit_idx_q;
    upd       = ent_q;
    case (req_q)
      pza_pkg::REQ_FRESET: begin
        r_status = pza_pkg::ST_OK;
        used_d   = (EIW+1)'(1);
        cur_d    = '0;
        frame_d  = '0;
        rtot_d   = '0;
        rstamp_d = ts_q;
      end
      pza_pkg::REQ_START: begin
        if (found_q) begin
          upd.stamp = ts_q;
          if (ent_q.count != {pza_pkg::CNT_W{1'b1}}) upd.count = ent_q.count + 1'b1;
          ent_we   = cmd_i.commit;
          r_status = pza_pkg::ST_OK;
          r_idx    = 8'(hit_idx_q);
        end else if (room) begin
          upd.key    = key_q;
          upd.stamp  = ts_q;
          upd.total  = '0;
          upd.count  = pza_pkg::CNT_W'(1);
          upd.level  = new_lvl;
          upd.parent = cur_q;
          ent_waddr  = used_q[EIW-1:0];
          ent_we     = cmd_i.commit;
          used_d     = used_q + (EIW+1)'(1);
          cur_d      = used_q[EIW-1:0];
          r_status   = pza_pkg::ST_INSERT;
          r_idx      = 8'(used_q[EIW-1:0]);
        end else begin
          r_status = pza_pkg::ST_FULL;
        end
        if (found_q || room) begin
          r_cnt = upd.count;
          r_tot = upd.total;
          r_lvl = upd.level;
          r_par = 8'(upd.parent);
        end
      end
      pza_pkg::REQ_END: begin
        if (found_q) begin
          upd.total = sat_add(ent_q.total, el_q);
          frame_d   = sat_add(frame_q, el_q);
          cur_d     = ent_q.parent;
          ent_we    = cmd_i.commit;
          r_status  = pza_pkg::ST_OK;
          r_idx     = 8'(hit_idx_q);
          r_cnt     = upd.count;
          r_tot     = upd.total;
          r_lvl     = upd.level;
          r_par     = 8'(upd.parent);
        end
      end
      pza_pkg::REQ_FINISH: begin
        r_status = pza_pkg::ST_OK;
        frame_d  = el_q;
        rtot_d   = el_q;
        r_tot    = el_q;
        r_hist   = el_q;
        hist_we  = cmd_i.commit;
        hptr_d   = (hptr_q == HIW'(HISTORY_DEPTH - 1)) ? '0 : hptr_q + 1'b1;
        hfill_d  = (hfill_q == (HIW+1)'(HISTORY_DEPTH)) ? hfill_q : hfill_q + 1'b1;
      end
      pza_pkg::REQ_RD_ENTRY: begin
        r_idx = ridx_q;
        if (ridx_ok_e) begin
          r_status = pza_pkg::ST_OK;
          if (ridx_q == 8'd0) begin
            r_tot = rtot_q;
          end else begin
            r_cnt = ent_q.count;
            r_tot = ent_q.total;
            r_lvl = ent_q.level;
            r_par = 8'(ent_q.parent);
          end
        end
      end
      pza_pkg::REQ_RD_HIST: begin
        if (ridx_ok_h) begin
          r_status = pza_pkg::ST_OK;
          r_hist   = hval_q[ridx_q[HIW-1:0]] ? hist_q : '0;
        end
      end
      default: begin
        r_status = pza_pkg::ST_MISS;
      end
    endcase
    ent_wdata = upd;
  end

  // table state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= (EIW+1)'(1);
      cur_q    <= '0;
      frame_q  <= '0;
      rstamp_q <= '0;
      rtot_q   <= '0;
      hptr_q   <= '0;
      hfill_q  <= '0;
      hval_q   <= '0;
    end else if (cmd_i.commit) begin
      used_q   <= used_d;
      cur_q    <= cur_d;
      frame_q  <= frame_d;
      rstamp_q <= rstamp_d;
      rtot_q   <= rtot_d;
      hptr_q   <= hptr_d;
      hfill_q  <= hfill_d;
      if (hist_we) hval_q[hptr_q] <= 1'b1;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o        <= r_status;
      entry_index_o   <= r_idx;
      invoke_count_o  <= r_cnt;
      total_ticks_o   <= r_tot;
      nesting_level_o <= r_lvl;
      parent_index_o  <= r_par;
      entry_count_o   <= 9'(used_d);
      frame_ticks_o   <= frame_d;
      history_ticks_o <= r_hist;
      history_count_o <= 6'(hfill_d);
    end
  end

endmodule
`default_nettype wire

/* rtl/profile_zone_accumulator.sv */
// Hierarchical zone profiling table.
// Input channel (in_valid_i / in_stall_o) carries one request item: frame
// reset, zone start, zone end, frame finish, read entry or read history.
// Output channel (out_valid_o / out_stall_i) returns exactly one result item
// per request, held in an output register.
// Zone start and zone end scan the entry memory for the key, one entry per
// cycle through its registered read port, over the entries in use. One item
// is in work at a time; the next is taken once the result has been written
// to the output register.
// Reset leaves only the root entry in use, the frame total zero and the
// history empty; no memory sweep is needed.
// While the receiver stalls, the result stays put and a finished item waits
// in its last step until the output register frees.
`default_nettype none
module profile_zone_accumulator #(
  parameter int ENTRIES       = 256,
  parameter int HISTORY_DEPTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  req_type_i,
  input  wire logic [pza_pkg::KEY_W-1:0]   zone_key_i,
  input  wire logic [pza_pkg::TICK_W-1:0]  timestamp_i,
  input  wire logic [7:0]                  read_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic [7:0]                       entry_index_o,
  output logic [pza_pkg::CNT_W-1:0]        invoke_count_o,
  output logic [pza_pkg::TICK_W-1:0]       total_ticks_o,
  output logic [7:0]                       nesting_level_o,
  output logic [7:0]                       parent_index_o,
  output logic [8:0]                       entry_count_o,
  output logic [pza_pkg::TICK_W-1:0]       frame_ticks_o,
  output logic [pza_pkg::TICK_W-1:0]       history_ticks_o,
  output logic [5:0]                       history_count_o
);

  pza_pkg::cmd_t  cmd;
  pza_pkg::stat_t st;

  pza_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  pza_dpath #(.ENTRIES(ENTRIES), .HISTORY_DEPTH(HISTORY_DEPTH)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .req_type_i      (req_type_i),
    .zone_key_i      (zone_key_i),
    .timestamp_i     (timestamp_i),
    .read_index_i    (read_index_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .entry_index_o   (entry_index_o),
    .invoke_count_o  (invoke_count_o),
    .total_ticks_o   (total_ticks_o),
    .nesting_level_o (nesting_level_o),
    .parent_index_o  (parent_index_o),
    .entry_count_o   (entry_count_o),
    .frame_ticks_o   (frame_ticks_o),
    .history_ticks_o (history_ticks_o),
    .history_count_o (history_count_o)
  );

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.scan, cmd.rd, cmd.calc, cmd.commit}))
    else $error("more than one datapath command");

  // an accepted item blocks the next one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // commit never overwrites a stalled result
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !out_valid_o || !out_stall_i)
    else $error("result overwritten");

  // a full table reports no entry
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pza_pkg::ST_FULL |-> entry_index_o == 8'd0 &&
      invoke_count_o == '0)
    else $error("full status with entry data");

endmodule
`default_nettype wire
